// ===== hdl/lox_pkg.sv =====
// ----------------------------------------------------------------------------
// lox_pkg
// shared types and constants of the lowered-op register executor
// ----------------------------------------------------------------------------
package lox_pkg;

	// register file geometry
	localparam int REG_COUNT  = 16;
	localparam int DATA_W     = 32;
	localparam int IDX_FIELD_W = 8;
	localparam int ADDR_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int RAM_DEPTH  = 1 << ADDR_W;
	localparam logic [IDX_FIELD_W-1:0] REG_LIMIT = IDX_FIELD_W'(REG_COUNT);

	// operation codes; codes 8 to 15 are unknown
	typedef enum logic [3:0] {
		KIND_NOP      = 4'd0,
		KIND_CLEAR_T  = 4'd1,
		KIND_SET_T    = 4'd2,
		KIND_MOVE_T   = 4'd3,
		KIND_SET_IMM  = 4'd4,
		KIND_ADD_IMM  = 4'd5,
		KIND_COPY_REG = 4'd6,
		KIND_ADD_REG  = 4'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	// input beat
	typedef struct packed {
		kind_t                   kind;
		logic [IDX_FIELD_W-1:0]  dest_index;
		logic [IDX_FIELD_W-1:0]  source_index;
		logic signed [DATA_W-1:0] immediate;
	} op_beat_t;

	// result beat
	typedef struct packed {
		status_t             status;
		logic                wrote_register;
		logic [DATA_W-1:0]   written_value;
		logic                t_value;
	} res_beat_t;

	// register file write request
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} wr_req_t;

endpackage

// ===== hdl/lox_ram.sv =====
// ----------------------------------------------------------------------------
// lox_ram
// generic single-write, single-read ram with registered read (read-old)
// ----------------------------------------------------------------------------
module lox_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/lox_exec.sv =====
// ----------------------------------------------------------------------------
// lox_exec
// decode, range check and compute of one operation
// ----------------------------------------------------------------------------
module lox_exec (
	input  lox_pkg::op_beat_t         op,
	input  logic [lox_pkg::DATA_W-1:0] dst_data,
	input  logic [lox_pkg::DATA_W-1:0] src_data,
	input  logic                      t_cur,
	output lox_pkg::res_beat_t        res,
	output lox_pkg::wr_req_t          wr,
	output logic                      t_next
);
	import lox_pkg::*;

	logic              dst_ok;
	logic              src_ok;
	logic [DATA_W-1:0] imm_u;

	assign dst_ok = op.dest_index < REG_LIMIT;
	assign src_ok = op.source_index < REG_LIMIT;
	assign imm_u  = DATA_W'(unsigned'(op.immediate));

	always_comb begin
		res.status         = ST_OK;
		res.wrote_register = 1'b0;
		res.written_value  = '0;
		t_next             = t_cur;

		unique case (op.kind)
			KIND_NOP: begin
			end
			KIND_CLEAR_T: begin
				t_next = 1'b0;
			end
			KIND_SET_T: begin
				t_next = 1'b1;
			end
			KIND_MOVE_T, KIND_SET_IMM, KIND_ADD_IMM: begin
				if (!dst_ok) begin
					res.status = ST_RANGE;
				end else begin
					res.wrote_register = 1'b1;
					if (op.kind == KIND_MOVE_T) begin
						res.written_value = DATA_W'(t_cur);
					end else if (op.kind == KIND_SET_IMM) begin
						res.written_value = imm_u;
					end else begin
						res.written_value = dst_data + imm_u;
					end
				end
			end
			KIND_COPY_REG, KIND_ADD_REG: begin
				if (!dst_ok || !src_ok) begin
					res.status = ST_RANGE;
				end else begin
					res.wrote_register = 1'b1;
					if (op.kind == KIND_COPY_REG) begin
						res.written_value = src_data;
					end else begin
						res.written_value = dst_data + src_data;
					end
				end
			end
			default: begin
				res.status = ST_UNKNOWN;
			end
		endcase

		res.t_value = t_next;
	end

	assign wr.en   = res.wrote_register;
	assign wr.addr = op.dest_index[ADDR_W-1:0];
	assign wr.data = res.written_value;

endmodule

// ===== hdl/lowered_op_register_executor_core.sv =====
// ----------------------------------------------------------------------------
// lowered_op_register_executor_core
// executes lowered operations on a 32-bit register file and a t flag
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------
//  op      | in        | op_valid / op_ready  | op  (op_beat_t)
//  res     | out       | res_valid / res_ready| res (res_beat_t)
//
// one beat per cycle sustained while res_ready is high; an accepted op beat is
// registered into the execute stage as the ram is read, then its result is
// loaded into the result register
// the register file sits in two ram copies (dest and source read ports);
// a write from the previous op is forwarded into the next op's operands
// reset clears per-entry valid bits at once: unwritten entries read as zero,
// so there is no clearing pass
// a stalled result register holds the execute stage; op_ready follows it
//
module lowered_op_register_executor_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  lox_pkg::op_beat_t  op,
	output logic               res_valid,
	input  logic               res_ready,
	output lox_pkg::res_beat_t res
);
	import lox_pkg::*;

	// execute stage
	logic              vld_s1;
	op_beat_t          op_s1;
	logic              adv_s1;
	logic              op_acc;

	// result register
	logic              res_vld_q;
	res_beat_t         res_q;

	// architectural t flag and register valid bits
	logic                 t_q;
	logic [RAM_DEPTH-1:0] reg_vld_q;

	// last write, for forwarding into the op that read the ram alongside it
	wr_req_t           fwd_q;

	// ram ports
	logic [ADDR_W-1:0] rd_dst_addr;
	logic [ADDR_W-1:0] rd_src_addr;
	logic [DATA_W-1:0] ram_dst;
	logic [DATA_W-1:0] ram_src;
	logic [ADDR_W-1:0] dst_addr_s1;
	logic [ADDR_W-1:0] src_addr_s1;
	logic [DATA_W-1:0] dst_opnd;
	logic [DATA_W-1:0] src_opnd;

	// execute outputs
	res_beat_t         ex_res;
	wr_req_t           ex_wr;
	logic              ex_t;
	logic              wr_fire;

	// handshake
	assign adv_s1   = vld_s1 && (!res_vld_q || res_ready);
	assign op_ready = !vld_s1 || adv_s1;
	assign op_acc   = op_valid && op_ready;
	assign wr_fire  = adv_s1 && ex_wr.en;

	// read the new beat's registers when taking one, else re-read the held beat
	assign dst_addr_s1 = op_s1.dest_index[ADDR_W-1:0];
	assign src_addr_s1 = op_s1.source_index[ADDR_W-1:0];
	assign rd_dst_addr = op_ready ? op.dest_index[ADDR_W-1:0] : dst_addr_s1;
	assign rd_src_addr = op_ready ? op.source_index[ADDR_W-1:0] : src_addr_s1;

	lox_ram #(
		.WIDTH (DATA_W),
		.DEPTH (RAM_DEPTH)
	) u_ram_dst (
		.clk   (clk),
		.we    (wr_fire),
		.waddr (ex_wr.addr),
		.wdata (ex_wr.data),
		.raddr (rd_dst_addr),
		.rdata (ram_dst)
	);

	lox_ram #(
		.WIDTH (DATA_W),
		.DEPTH (RAM_DEPTH)
	) u_ram_src (
		.clk   (clk),
		.we    (wr_fire),
		.waddr (ex_wr.addr),
		.wdata (ex_wr.data),
		.raddr (rd_src_addr),
		.rdata (ram_src)
	);

	// operand select: forwarded write, then ram, then zero for unwritten entries
	always_comb begin
		if (fwd_q.en && fwd_q.addr == dst_addr_s1) begin
			dst_opnd = fwd_q.data;
		end else if (reg_vld_q[dst_addr_s1]) begin
			dst_opnd = ram_dst;
		end else begin
			dst_opnd = '0;
		end

		if (fwd_q.en && fwd_q.addr == src_addr_s1) begin
			src_opnd = fwd_q.data;
		end else if (reg_vld_q[src_addr_s1]) begin
			src_opnd = ram_src;
		end else begin
			src_opnd = '0;
		end
	end

	lox_exec u_exec (
		.op       (op_s1),
		.dst_data (dst_opnd),
		.src_data (src_opnd),
		.t_cur    (t_q),
		.res      (ex_res),
		.wr       (ex_wr),
		.t_next   (ex_t)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
			t_q       <= 1'b0;
			reg_vld_q <= '0;
			fwd_q     <= '0;
		end else begin
			if (op_ready) begin
				vld_s1 <= op_acc;
			end
			if (adv_s1) begin
				res_vld_q <= 1'b1;
				t_q       <= ex_t;
			end else if (res_ready) begin
				res_vld_q <= 1'b0;
			end
			if (wr_fire) begin
				reg_vld_q[ex_wr.addr] <= 1'b1;
			end
			fwd_q.en   <= wr_fire;
			fwd_q.addr <= ex_wr.addr;
			fwd_q.data <= ex_wr.data;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (op_acc) begin
			op_s1 <= op;
		end
		if (adv_s1) begin
			res_q <= ex_res;
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

endmodule
